// File: design/cds_pkg.sv
// Shared types, constants and calendar helper functions for the date stepper.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package cds_pkg;

   localparam int unsigned YEAR_LOW_DEF  = 1753;
   localparam int unsigned YEAR_HIGH_DEF = 9999;
   localparam int unsigned QUEUE_DEPTH   = 2;

   // Reciprocal for a 14-bit divide by 100: q = (y * 5243) >> 19, exact up to 16383
   localparam int unsigned DIV100_MUL   = 5243;
   localparam int unsigned DIV100_SHIFT = 19;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;
   localparam logic [4:0] LEAP_FEB_DAYS = 5'd29;
   localparam logic [4:0] FEB_DAYS      = 5'd28;
   localparam logic [4:0] LONG_MONTH    = 5'd31;
   localparam logic [6:0] YY_LAST       = 7'd99;

   typedef logic [13:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [6:0]  cent_type;
   typedef logic [6:0]  yy_type;
   typedef logic [2:0]  weekday_type;

   typedef enum logic [2:0] {
      KIND_SET,
      KIND_NEXT_DAY,
      KIND_PREV_DAY,
      KIND_NEXT_MONTH,
      KIND_PREV_MONTH,
      KIND_NEXT_YEAR,
      KIND_PREV_YEAR,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_SET,
      STATUS_RANGE
   } status_type;

   // Classified command as it sits in the queue between front and back
   typedef struct packed {
      kind_type  kind;
      year_type  set_year;
      cent_type  set_cent;
      yy_type    set_yy;
      month_type set_month;
      day_type   set_day;
      logic      set_ok;
   } cmd_type;

   typedef struct packed {
      logic [7:0] cent;
      yy_type     yy;
   } year_split_type;

   function automatic year_split_type split_year(year_type y);
      logic [26:0]    prod;
      logic [7:0]     q;
      year_type       rem;
      year_split_type s;
      prod   = 27'(y) * 27'(DIV100_MUL);
      q      = prod[26:DIV100_SHIFT];
      rem    = y - 14'(14'(q) * 14'd100);
      s.cent = q;
      s.yy   = rem[6:0];
      return s;
   endfunction

   // y = 100*cent + yy: divisible by 4 follows yy, the century rule follows cent
   function automatic logic is_leap(logic [1:0] cent_lo, yy_type yy);
      return (yy == '0) ? (cent_lo == 2'd0) : (yy[1:0] == 2'd0);
   endfunction

   // Month outside 1..12 is treated as January
   function automatic day_type month_len(month_type m, logic leap);
      day_type len;
      case (m)
         MONTH_FEB:                 len = leap ? LEAP_FEB_DAYS : FEB_DAYS;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = LONG_MONTH;
      endcase
      return len;
   endfunction

   function automatic weekday_type century_code(logic [2:0] idx);
      weekday_type c;
      case (idx)
         3'd0, 3'd4: c = 3'd4;
         3'd1, 3'd5: c = 3'd2;
         3'd2, 3'd6: c = 3'd0;
         default:    c = 3'd6;
      endcase
      return c;
   endfunction

   function automatic weekday_type month_code(month_type m, logic leap);
      weekday_type c;
      case (m)
         4'd2:       c = leap ? 3'd2 : 3'd3;
         4'd3:       c = 3'd3;
         4'd4:       c = 3'd6;
         4'd5:       c = 3'd1;
         4'd6:       c = 3'd4;
         4'd7:       c = 3'd6;
         4'd8:       c = 3'd2;
         4'd9:       c = 3'd5;
         4'd10:      c = 3'd0;
         4'd11:      c = 3'd3;
         4'd12:      c = 3'd5;
         default:    c = leap ? 3'd6 : 3'd0;
      endcase
      return c;
   endfunction

   // 8 is 1 mod 7: fold octal digits three times, then map 7 to 0
   function automatic weekday_type mod7(logic [7:0] x);
      logic [5:0] f1;
      logic [3:0] f2;
      logic [3:0] f3;
      f1 = 6'(x[7:3]) + 6'(x[2:0]);
      f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
      f3 = 4'(f2[3]) + 4'(f2[2:0]);
      return (f3[2:0] == 3'd7) ? 3'd0 : f3[2:0];
   endfunction

endpackage

// File: design/cds_if.sv
// Request and response channel interfaces for the date stepper.
// Depends on cds_pkg for the field types.
`timescale 1ns / 1ps

interface cds_req_if;
   import cds_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   year_type   set_year;
   month_type  set_month;
   day_type    set_day;

   modport source (output valid, kind, set_year, set_month, set_day, input ready);
   modport sink   (input valid, kind, set_year, set_month, set_day, output ready);
endinterface

interface cds_rsp_if;
   import cds_pkg::*;
   logic        valid;
   logic        ready;
   year_type    year_now;
   month_type   month_now;
   day_type     day_now;
   weekday_type weekday;
   logic        leap;
   logic [1:0]  status;

   modport source (output valid, year_now, month_now, day_now, weekday, leap, status,
                   input ready);
   modport sink   (input valid, year_now, month_now, day_now, weekday, leap, status,
                   output ready);
endinterface

// File: design/cds_front.sv
// Front end: accepts request words, validates set arguments, queues commands.
// Depends on cds_pkg and cds_req_if.
`timescale 1ns / 1ps

module cds_front #(
   parameter int unsigned YEAR_LOW  = cds_pkg::YEAR_LOW_DEF,
   parameter int unsigned YEAR_HIGH = cds_pkg::YEAR_HIGH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   cds_req_if.sink          req,
   output cds_pkg::cmd_type head,
   output logic             head_valid,
   input  logic             head_pop
);
   import cds_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   year_split_type split;
   logic           set_leap;
   cmd_type        cmd;
   logic           push;

   // Classify: split the set year and check the set arguments
   always_comb begin
      split         = split_year(req.set_year);
      set_leap      = is_leap(split.cent[1:0], split.yy);
      cmd.kind      = kind_type'(req.kind);
      cmd.set_year  = req.set_year;
      cmd.set_cent  = split.cent[6:0];
      cmd.set_yy    = split.yy;
      cmd.set_month = req.set_month;
      cmd.set_day   = req.set_day;
      cmd.set_ok    = (req.set_year >= 14'(YEAR_LOW)) && (req.set_year <= 14'(YEAR_HIGH)) &&
                      (req.set_month >= MONTH_JAN) && (req.set_month <= MONTH_DEC) &&
                      (req.set_day != '0) &&
                      (req.set_day <= month_len(req.set_month, set_leap));
   end

   assign req.ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push     ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (!push && head_pop) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Clear the slots at reset so the head never carries an unknown kind
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// File: design/cds_back.sv
// Back end: holds the date, executes queued commands, registers the response word.
// Depends on cds_pkg and cds_rsp_if.
`timescale 1ns / 1ps

module cds_back #(
   parameter int unsigned YEAR_LOW  = cds_pkg::YEAR_LOW_DEF,
   parameter int unsigned YEAR_HIGH = cds_pkg::YEAR_HIGH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cds_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             head_pop,
   cds_rsp_if.source        rsp
);
   import cds_pkg::*;

   localparam cent_type RST_CENT = 7'(YEAR_LOW / 100);
   localparam yy_type   RST_YY   = 7'(YEAR_LOW % 100);

   // Date state; the year is also kept split into century and year of century
   year_type  year_ff, year_in;
   cent_type  cent_ff, cent_in;
   yy_type    yy_ff, yy_in;
   month_type month_ff, month_in;
   day_type   day_ff, day_in;

   logic        out_valid_ff;
   year_type    out_year_ff;
   month_type   out_month_ff;
   day_type     out_day_ff;
   weekday_type out_weekday_ff, weekday_in;
   logic        out_leap_ff, leap_in;
   status_type  out_status_ff, status_in;

   cent_type  inc_cent, dec_cent;
   yy_type    inc_yy, dec_yy;
   logic      leap_cur, leap_inc, leap_dec;
   logic      can_inc, can_dec;
   day_type   len_cur, len_prev, len_next;
   logic [7:0] dow_sum;

   assign head_pop = head_valid && (!out_valid_ff || rsp.ready);

   // Neighbor years and the month lengths around the current date
   always_comb begin
      inc_yy   = (yy_ff == YY_LAST) ? '0 : 7'(yy_ff + 1'b1);
      inc_cent = (yy_ff == YY_LAST) ? 7'(cent_ff + 1'b1) : cent_ff;
      dec_yy   = (yy_ff == '0) ? YY_LAST : 7'(yy_ff - 1'b1);
      dec_cent = (yy_ff == '0) ? 7'(cent_ff - 1'b1) : cent_ff;
      leap_cur = is_leap(cent_ff[1:0], yy_ff);
      leap_inc = is_leap(inc_cent[1:0], inc_yy);
      leap_dec = is_leap(dec_cent[1:0], dec_yy);
      can_inc  = (year_ff < 14'(YEAR_HIGH));
      can_dec  = (year_ff > 14'(YEAR_LOW));
      len_cur  = month_len(month_ff, leap_cur);
      len_prev = month_len(4'(month_ff - 1'b1), leap_cur);
      len_next = month_len(4'(month_ff + 1'b1), leap_cur);
   end

   always_comb begin
      year_in   = year_ff;
      cent_in   = cent_ff;
      yy_in     = yy_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      status_in = STATUS_OK;
      unique case (head.kind)
         KIND_SET: begin
            if (head.set_ok) begin
               year_in  = head.set_year;
               cent_in  = head.set_cent;
               yy_in    = head.set_yy;
               month_in = head.set_month;
               day_in   = head.set_day;
            end else begin
               status_in = STATUS_BAD_SET;
            end
         end
         KIND_NEXT_DAY: begin
            if (day_ff < len_cur) begin
               day_in = 5'(day_ff + 1'b1);
            end else if (month_ff < MONTH_DEC) begin
               month_in = 4'(month_ff + 1'b1);
               day_in   = 5'd1;
            end else if (can_inc) begin
               year_in  = 14'(year_ff + 1'b1);
               cent_in  = inc_cent;
               yy_in    = inc_yy;
               month_in = MONTH_JAN;
               day_in   = 5'd1;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_PREV_DAY: begin
            if (day_ff > 5'd1) begin
               day_in = 5'(day_ff - 1'b1);
            end else if (month_ff > MONTH_JAN) begin
               month_in = 4'(month_ff - 1'b1);
               day_in   = len_prev;
            end else if (can_dec) begin
               year_in  = 14'(year_ff - 1'b1);
               cent_in  = dec_cent;
               yy_in    = dec_yy;
               month_in = MONTH_DEC;
               day_in   = LONG_MONTH;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_NEXT_MONTH: begin
            // January has 31 days, so a year wrap keeps the day as it is
            if (month_ff < MONTH_DEC) begin
               month_in = 4'(month_ff + 1'b1);
               day_in   = (day_ff > len_next) ? len_next : day_ff;
            end else if (can_inc) begin
               year_in  = 14'(year_ff + 1'b1);
               cent_in  = inc_cent;
               yy_in    = inc_yy;
               month_in = MONTH_JAN;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_PREV_MONTH: begin
            if (month_ff > MONTH_JAN) begin
               month_in = 4'(month_ff - 1'b1);
               day_in   = (day_ff > len_prev) ? len_prev : day_ff;
            end else if (can_dec) begin
               year_in  = 14'(year_ff - 1'b1);
               cent_in  = dec_cent;
               yy_in    = dec_yy;
               month_in = MONTH_DEC;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_NEXT_YEAR: begin
            if (can_inc) begin
               year_in = 14'(year_ff + 1'b1);
               cent_in = inc_cent;
               yy_in   = inc_yy;
               if (month_ff == MONTH_FEB && day_ff == LEAP_FEB_DAYS && !leap_inc) begin
                  day_in = FEB_DAYS;
               end
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_PREV_YEAR: begin
            if (can_dec) begin
               year_in = 14'(year_ff - 1'b1);
               cent_in = dec_cent;
               yy_in   = dec_yy;
               if (month_ff == MONTH_FEB && day_ff == LEAP_FEB_DAYS && !leap_dec) begin
                  day_in = FEB_DAYS;
               end
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         KIND_READ: begin
         end
      endcase
   end

   // Weekday of the new date from the century and month tables
   always_comb begin
      leap_in    = is_leap(cent_in[1:0], yy_in);
      dow_sum    = 8'(century_code(3'(cent_in[2:0] + 3'd7))) + 8'(yy_in) +
                   8'(yy_in[6:2]) + 8'(month_code(month_in, leap_in)) + 8'(day_in);
      weekday_in = mod7(dow_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff      <= 14'(YEAR_LOW);
         cent_ff      <= RST_CENT;
         yy_ff        <= RST_YY;
         month_ff     <= MONTH_JAN;
         day_ff       <= 5'd1;
         out_valid_ff <= 1'b0;
      end else if (head_pop) begin
         year_ff      <= year_in;
         cent_ff      <= cent_in;
         yy_ff        <= yy_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         out_year_ff    <= year_in;
         out_month_ff   <= month_in;
         out_day_ff     <= day_in;
         out_weekday_ff <= weekday_in;
         out_leap_ff    <= leap_in;
         out_status_ff  <= status_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.year_now  = out_year_ff;
   assign rsp.month_now = out_month_ff;
   assign rsp.day_now   = out_day_ff;
   assign rsp.weekday   = out_weekday_ff;
   assign rsp.leap      = out_leap_ff;
   assign rsp.status    = out_status_ff;

endmodule

// File: design/calendar_date_stepper_core.sv
// Top level of the Gregorian date stepper: front end, command queue, back end.
// Depends on cds_pkg, cds_if, cds_front and cds_back.
`timescale 1ns / 1ps

// Usage
//   req: one command word per valid/ready handshake. kind selects set, step one
//        day, month or year forward or back, or read; set_year, set_month and
//        set_day matter only for a set.
//   rsp: exactly one word per command, in command order: the stored date after
//        the command, its weekday (0 Sunday), the leap flag and a status
//        (ok, invalid set arguments, step beyond the year limits). On an error
//        the date is left unchanged and reported as stored.
//   Path: an accepted command is written into the queue, then popped from the
//        queue head into the date and response registers, which raise valid.
//   Throughput: one command per cycle while rsp.ready stays high. The date
//        registers in the back end close their update loop through combinational
//        logic only; the two-word queue and the response register let the
//        request side keep going while a response waits.
//   Reset: synchronous; the date becomes January 1 of YEAR_LOW, the queue and
//        the response register are emptied.
//   Stall: while rsp.ready is low the response word holds, the back end stops
//        and the queue fills; req.ready drops once two commands are queued.
module calendar_date_stepper_core #(
   parameter int unsigned YEAR_LOW  = cds_pkg::YEAR_LOW_DEF,
   parameter int unsigned YEAR_HIGH = cds_pkg::YEAR_HIGH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cds_req_if.sink    req,
   cds_rsp_if.source  rsp
);
   import cds_pkg::*;

   cmd_type head;
   logic    head_valid;
   logic    head_pop;

   // Accept and classify; set arguments are checked before queueing
   cds_front #(
      .YEAR_LOW  (YEAR_LOW),
      .YEAR_HIGH (YEAR_HIGH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Execute against the stored date and hold the response word
   cds_back #(
      .YEAR_LOW  (YEAR_LOW),
      .YEAR_HIGH (YEAR_HIGH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp        (rsp)
   );

endmodule

// File: design/cds_checker.sv
// Port-level checks on the response channel of the date stepper, and their bind.
// Depends on cds_pkg and calendar_date_stepper_core.
`timescale 1ns / 1ps

module cds_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [13:0] year_now,
   input logic [3:0] month_now,
   input logic [4:0] day_now,
   input logic [2:0] weekday,
   input logic       leap,
   input logic [1:0] status
);
   import cds_pkg::*;

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(year_now) && $stable(month_now) &&
      $stable(day_now) && $stable(weekday) && $stable(status))
      else $error("response word changed while stalled");

   // Drop any response after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> month_now >= MONTH_JAN && month_now <= MONTH_DEC && day_now != 5'd0 &&
      weekday != 3'd7 &&
      (status == STATUS_OK || status == STATUS_BAD_SET || status == STATUS_RANGE))
      else $error("response date or code out of range");

   a_feb29_leap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && month_now == MONTH_FEB && day_now == LEAP_FEB_DAYS |-> leap)
      else $error("February 29 in a common year");

endmodule

bind calendar_date_stepper_core cds_checker u_cds_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .year_now  (rsp.year_now),
   .month_now (rsp.month_now),
   .day_now   (rsp.day_now),
   .weekday   (rsp.weekday),
   .leap      (rsp.leap),
   .status    (rsp.status)
);
